// ===== sv/ccs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types, sizes and helpers for the cocktail shaker sorter.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int DEPTH  = 64;                  // elements held per set
    localparam int DATA_W = 32;                  // element width
    localparam int IDX_W  = $clog2(DEPTH);       // store address width
    localparam int CNT_W  = $clog2(DEPTH + 1);   // element count, holds DEPTH itself
    localparam int STAT_W = 12;                  // compare / swap totals

    localparam logic [STAT_W-1:0] STAT_MAX = '1;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     end_of_set;
        logic [STAT_W-1:0]        compare_count;
        logic [STAT_W-1:0]        swap_count;
        logic                     overflow;
    } t_out_item;

    // Result of one compare-exchange step
    typedef struct packed {
        logic                     swap;     // pair out of order, exchange it
        logic signed [DATA_W-1:0] wr_data;  // value to store at the current position
        logic signed [DATA_W-1:0] carry;    // value carried on to the next position
    } t_cmp_res;

    // Saturating increment for the statistics counters
    function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] cnt);
        sat_inc = (cnt == STAT_MAX) ? cnt : cnt + STAT_W'(1);
    endfunction

endpackage
`default_nettype wire

// ===== sv/ccs_cmp_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_cmp_unit
// Compare-exchange step shared by the forward and backward passes.
// ----------------------------------------------------------------------------
module ccs_cmp_unit (
    input  wire logic                             i_fwd,
    input  wire logic signed [ccs_pkg::DATA_W-1:0] i_carry,
    input  wire logic signed [ccs_pkg::DATA_W-1:0] i_fetched,
    output ccs_pkg::t_cmp_res                     o_res
);
    import ccs_pkg::*;

    logic out_of_order;

    // Forward: carry sits below the fetched element. Backward: above it.
    assign out_of_order = i_fwd ? (i_carry > i_fetched) : (i_fetched > i_carry);

    // On a swap the fetched element drops into the current slot and the
    // carry keeps moving; otherwise the carry settles in the current slot
    // and the fetched element becomes the carry.
    assign o_res.swap    = out_of_order;
    assign o_res.wr_data = out_of_order ? i_fetched : i_carry;
    assign o_res.carry   = out_of_order ? i_carry : i_fetched;

endmodule
`default_nettype wire

// ===== sv/cocktail_shaker_sorter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cocktail_shaker_sorter_top
// Collects a set of signed words, sorts it with a cocktail shaker sort and
// streams the sorted set back out.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while it loads a set, up to DEPTH
// (64) elements; requests beyond that are dropped and flagged on the final
// result. A request with last_item closes the set; the block then drops
// o_in_ready and sorts in place in a 64-entry single-port-write store, one
// compare-exchange per cycle through one shared compare unit, with S_SETUP
// and S_PRIME for the pass setup and S_END for the write-back of the
// carried element. A full 64-element reversed set costs 2016 compares
// over 63 passes. Results then leave in ascending order; each is loaded
// in S_EMIT_LD and held in S_HOLD until the consumer accepts it. The
// last one carries end_of_set, the saturating compare and swap totals,
// and the overflow flag. Every compare step writes the current slot,
// swap or not. New requests are taken again once the final result has
// been accepted.
// ----------------------------------------------------------------------------
module cocktail_shaker_sorter_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire ccs_pkg::t_in_item   i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output ccs_pkg::t_out_item       o_out
);
    import ccs_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,     // take requests into the store
        S_SETUP,    // fetch the element at the pass start
        S_PRIME,    // latch it as carry, fetch its neighbor
        S_STEP,     // one compare-exchange per cycle
        S_END,      // write back the carry, narrow the bounds
        S_EMIT_RD,  // fetch the first sorted element
        S_EMIT_LD,  // load the output register
        S_HOLD      // wait for the consumer
    } t_state;

    // Sequencer registers
    t_state                   r_state,     n_state;
    logic                     r_fwd,       n_fwd;
    logic [CNT_W-1:0]         r_count,     n_count;
    logic                     r_ovf,       n_ovf;
    logic [IDX_W-1:0]         r_lb,        n_lb;
    logic [IDX_W-1:0]         r_ub,        n_ub;
    logic [IDX_W-1:0]         r_pos,       n_pos;
    logic [IDX_W-1:0]         r_last_swap, n_last_swap;
    logic [IDX_W-1:0]         r_emit,      n_emit;
    logic [STAT_W-1:0]        r_cmp_cnt,   n_cmp_cnt;
    logic [STAT_W-1:0]        r_swp_cnt,   n_swp_cnt;
    logic signed [DATA_W-1:0] r_carry,     n_carry;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out,       n_out;

    // Element store
    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic [IDX_W-1:0]         rd_addr;

    // Datapath helpers
    logic [IDX_W-1:0] pos_step;   // next compare position in the pass direction
    logic [IDX_W-1:0] pos_end;    // bound the current pass runs toward
    logic [IDX_W-1:0] pos_start;  // bound the current pass departs from
    logic             emit_fin;
    t_cmp_res         cmp;

    assign pos_step  = r_fwd ? r_pos + IDX_W'(1) : r_pos - IDX_W'(1);
    assign pos_end   = r_fwd ? r_ub : r_lb;
    assign pos_start = r_fwd ? r_lb : r_ub;
    assign emit_fin  = (CNT_W'(r_emit) + CNT_W'(1)) == r_count;

    ccs_cmp_unit u_cmp (
        .i_fwd     (r_fwd),
        .i_carry   (r_carry),
        .i_fetched (r_rd_data),
        .o_res     (cmp)
    );

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_fwd       = r_fwd;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_lb        = r_lb;
        n_ub        = r_ub;
        n_pos       = r_pos;
        n_last_swap = r_last_swap;
        n_emit      = r_emit;
        n_cmp_cnt   = r_cmp_cnt;
        n_swp_cnt   = r_swp_cnt;
        n_carry     = r_carry;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_pos;
        wr_data     = cmp.wr_data;
        rd_addr     = r_pos;

        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    // Store while there is room, otherwise drop and flag
                    if (r_count < CNT_W'(DEPTH)) begin
                        wr_en   = 1'b1;
                        wr_addr = r_count[IDX_W-1:0];
                        wr_data = i_in.value;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last_item) begin
                        n_lb      = '0;
                        n_ub      = IDX_W'(n_count - CNT_W'(1));
                        n_fwd     = 1'b1;
                        n_cmp_cnt = '0;
                        n_swp_cnt = '0;
                        n_emit    = '0;
                        n_state   = (n_count > CNT_W'(1)) ? S_SETUP : S_EMIT_RD;
                    end
                end
            end

            S_SETUP: begin
                rd_addr     = pos_start;
                n_pos       = pos_start;
                n_last_swap = pos_start;
                n_state     = S_PRIME;
            end

            S_PRIME: begin
                rd_addr = pos_step;
                n_carry = r_rd_data;
                n_state = S_STEP;
            end

            S_STEP: begin
                // Prefetch two ahead: the neighbor of the next position
                rd_addr   = r_fwd ? r_pos + IDX_W'(2) : r_pos - IDX_W'(2);
                n_cmp_cnt = sat_inc(r_cmp_cnt);
                // Settle the current slot every step, swap or not
                wr_en     = 1'b1;
                wr_addr   = r_pos;
                wr_data   = cmp.wr_data;
                if (cmp.swap) begin
                    n_swp_cnt   = sat_inc(r_swp_cnt);
                    n_last_swap = r_pos;
                end
                n_carry = cmp.carry;
                n_pos   = pos_step;
                if (pos_step == pos_end) begin
                    n_state = S_END;
                end
            end

            S_END: begin
                // The carry lands on the far bound of the pass
                wr_en   = 1'b1;
                wr_addr = r_pos;
                wr_data = r_carry;
                n_emit  = '0;
                if (r_fwd) begin
                    n_ub = r_last_swap;
                    if (r_lb < r_last_swap) begin
                        n_fwd   = 1'b0;
                        n_state = S_SETUP;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end else begin
                    n_lb = r_last_swap;
                    if (r_last_swap < r_ub) begin
                        n_fwd   = 1'b1;
                        n_state = S_SETUP;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end
            end

            S_EMIT_RD: begin
                rd_addr = r_emit;
                n_state = S_EMIT_LD;
            end

            S_EMIT_LD: begin
                rd_addr              = r_emit;
                n_out.sorted_value   = r_rd_data;
                n_out.end_of_set     = emit_fin;
                n_out.compare_count  = emit_fin ? r_cmp_cnt : '0;
                n_out.swap_count     = emit_fin ? r_swp_cnt : '0;
                n_out.overflow       = emit_fin ? r_ovf : 1'b0;
                n_out_valid          = 1'b1;
                n_state              = S_HOLD;
            end

            S_HOLD: begin
                // Keep the next element fetched while the result waits
                rd_addr = r_emit + IDX_W'(1);
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (emit_fin) begin
                        n_count     = '0;
                        n_ovf       = 1'b0;
                        n_cmp_cnt   = '0;
                        n_swp_cnt   = '0;
                        n_lb        = '0;
                        n_ub        = '0;
                        n_last_swap = '0;
                        n_state     = S_LOAD;
                    end else begin
                        n_emit  = r_emit + IDX_W'(1);
                        n_state = S_EMIT_LD;
                    end
                end
            end

            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_fwd       <= 1'b1;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_lb        <= '0;
            r_ub        <= '0;
            r_pos       <= '0;
            r_last_swap <= '0;
            r_emit      <= '0;
            r_cmp_cnt   <= '0;
            r_swp_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fwd       <= n_fwd;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_lb        <= n_lb;
            r_ub        <= n_ub;
            r_pos       <= n_pos;
            r_last_swap <= n_last_swap;
            r_emit      <= n_emit;
            r_cmp_cnt   <= n_cmp_cnt;
            r_swp_cnt   <= n_swp_cnt;
            r_carry     <= n_carry;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    // Element store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("result presented while requests are accepted");

    a_step_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_lb < r_ub && r_pos >= r_lb && r_pos <= r_ub))
        else $error("compare position outside the pass bounds");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count exceeds store depth");

    a_end_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.end_of_set) |-> emit_fin)
        else $error("end of set flagged before the last stored element");

endmodule
`default_nettype wire

// ===== sim/cocktail_shaker_sorter_top_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cocktail_shaker_sorter_top_tb
// Self-checking bench for the cocktail shaker sorter: sets of signed words go
// in, and each sorted set is compared word for word with a local sort.
// ----------------------------------------------------------------------------
module cocktail_shaker_sorter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccs_pkg::*;

    localparam int IDLE_PCT    = 7;       // chance per cycle that a side idles
    localparam int RANDOM_REQS = 180;     // requests in the random part
    localparam int SETTLE      = 50;      // quiet cycles after the last result
    localparam int CYCLE_LIMIT = 400000;  // watchdog

    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    logic      out_ready  = 1'b0;
    t_in_item  in_req     = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out;

    // Sorter state as the bench sees it
    logic signed [DATA_W-1:0] loaded_set[$];   // words held in the current set
    logic                     set_overflow;    // a word of this set was dropped
    t_out_item                pending_sorted_q[$];

    int  mismatch_cnt = 0;
    int  cycle_cnt    = 0;
    bit  no_idle      = 1'b0;                  // hold both sides busy

    cocktail_shaker_sorter_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (in_req),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out      (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sort the held set the way the block does and queue one result per word.
    // Each pass pulls its far bound in to where it last swapped, so a pass
    // with no swap closes the bounds and ends the sort.
    task automatic shaker_sort_predict();
        logic signed [DATA_W-1:0] work[$];
        logic signed [DATA_W-1:0] tmp;
        logic [STAT_W-1:0]        compares;
        logic [STAT_W-1:0]        swaps;
        t_out_item                res;
        int                       lo, hi, last_swap, i, n;
        work     = loaded_set;
        n        = work.size();
        compares = '0;
        swaps    = '0;
        lo       = 0;
        hi       = (n > 0) ? n - 1 : 0;
        while (lo < hi) begin
            last_swap = lo;
            for (i = lo; i < hi; i++) begin
                if (compares != '1) compares++;
                if (work[i] > work[i+1]) begin
                    tmp = work[i]; work[i] = work[i+1]; work[i+1] = tmp;
                    if (swaps != '1) swaps++;
                    last_swap = i;
                end
            end
            hi        = last_swap;
            last_swap = hi;
            for (i = hi; i > lo; i--) begin
                if (compares != '1) compares++;
                if (work[i-1] > work[i]) begin
                    tmp = work[i-1]; work[i-1] = work[i]; work[i] = tmp;
                    if (swaps != '1) swaps++;
                    last_swap = i;
                end
            end
            lo = last_swap;
        end
        // Totals and the overflow flag ride on the final word only
        for (i = 0; i < n; i++) begin
            res               = '0;
            res.sorted_value  = work[i];
            if (i == n - 1) begin
                res.end_of_set    = 1'b1;
                res.compare_count = compares;
                res.swap_count    = swaps;
                res.overflow      = set_overflow;
            end
            pending_sorted_q.push_back(res);
        end
        loaded_set.delete();
        set_overflow = 1'b0;
    endtask

    // Track one accepted request: store it, or drop it once the set is full
    task automatic load_element(input t_in_item req);
        if (loaded_set.size() < DEPTH) begin
            loaded_set.push_back(req.value);
        end else begin
            set_overflow = 1'b1;
        end
        if (req.last_item) shaker_sort_predict();
    endtask

    // Offer one request and hold it until the block takes it. Valid drops
    // only for an idle gap, so back-to-back requests keep it high.
    task automatic send_request(input t_in_item req);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        load_element(req);
    endtask

    // Send a whole set, marking the final word as last
    task automatic send_set(input logic signed [DATA_W-1:0] words[$]);
        t_in_item req;
        for (int k = 0; k < words.size(); k++) begin
            req.value     = words[k];
            req.last_item = (k == words.size() - 1);
            send_request(req);
        end
    endtask

    // Stall the sender until every queued result has come back
    task automatic drain_results(input int settle);
        in_valid <= 1'b0;
        while (pending_sorted_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Pick a word: full range, a narrow band with many ties, or an extreme
    function automatic logic signed [DATA_W-1:0] pick_word(input int mode);
        logic signed [DATA_W-1:0] w;
        case (mode)
            0: w = $urandom;
            1: w = $signed($urandom_range(8)) - 4;
            default: begin
                case ($urandom_range(5))
                    0: w = WORD_MIN;
                    1: w = WORD_MAX;
                    2: w = WORD_MIN + 1;
                    3: w = WORD_MAX - 1;
                    4: w = -1;
                    default: w = 0;
                endcase
            end
        endcase
        return w;
    endfunction

    // Receiver: stall at random, check each accepted result against the
    // oldest prediction, field by field
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        bit        bad;
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_sorted_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: value %0d last %0b cmp %0d swp %0d ovf %0b",
                             o_out.sorted_value, o_out.end_of_set, o_out.compare_count,
                             o_out.swap_count, o_out.overflow);
            end else begin
                want = pending_sorted_q.pop_front();
                bad  = (o_out.sorted_value  !== want.sorted_value)  ||
                       (o_out.end_of_set    !== want.end_of_set)    ||
                       (o_out.compare_count !== want.compare_count) ||
                       (o_out.swap_count    !== want.swap_count)    ||
                       (o_out.overflow      !== want.overflow);
                if (bad) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: want value %0d last %0b cmp %0d swp %0d ovf %0b, got value %0d last %0b cmp %0d swp %0d ovf %0b",
                                 want.sorted_value, want.end_of_set, want.compare_count,
                                 want.swap_count, want.overflow,
                                 o_out.sorted_value, o_out.end_of_set, o_out.compare_count,
                                 o_out.swap_count, o_out.overflow);
                end
            end
        end
    end

    // Single-word sets at both ends of the range: no compare at all
    task automatic test_single_word();
        logic signed [DATA_W-1:0] words[$];
        words = '{WORD_MIN};
        send_set(words);
        words = '{WORD_MAX};
        send_set(words);
    endtask

    // Extremes and ties in one set
    task automatic test_extremes();
        logic signed [DATA_W-1:0] words[$];
        words = '{WORD_MAX, WORD_MIN, 32'sd0, -32'sd1, 32'sd1, WORD_MIN, WORD_MAX};
        send_set(words);
    endtask

    // Already ascending: the first pass makes no swap and ends the sort
    task automatic test_presorted();
        logic signed [DATA_W-1:0] words[$];
        words = '{-32'sd3, -32'sd2, 32'sd0, 32'sd5, 32'sd9};
        send_set(words);
    endtask

    // Descending: every compare swaps
    task automatic test_reversed();
        logic signed [DATA_W-1:0] words[$];
        words = '{32'sd700, 32'sd600, 32'sd5, 32'sd0, -32'sd5, -32'sd600, -32'sd700,
                  WORD_MIN};
        send_set(words);
    endtask

    // Full store, then sets that run past it, the last request dropped too
    task automatic test_store_full();
        logic signed [DATA_W-1:0] words[$];
        words.delete();
        for (int k = 0; k < DEPTH; k++) words.push_back(DEPTH - k);
        send_set(words);
        words.delete();
        for (int k = 0; k < DEPTH + 1; k++) words.push_back(pick_word(0));
        send_set(words);
        words.delete();
        for (int k = 0; k < DEPTH + 3; k++) words.push_back(pick_word(k % 3));
        send_set(words);
        drain_results(SETTLE);
    endtask

    // Random sets, mostly short; a busy stretch in the middle and one full
    // stall of the sender until the results are out
    task automatic test_random_sets();
        logic signed [DATA_W-1:0] words[$];
        int  sent, size, roll, mode;
        bit  drained;
        sent    = 0;
        drained = 1'b0;
        while (sent < RANDOM_REQS) begin
            no_idle = (sent >= 40 && sent < 120);
            roll    = $urandom_range(99);
            if (roll < 75)      size = $urandom_range(10, 1);
            else if (roll < 93) size = $urandom_range(40, 11);
            else                size = $urandom_range(DEPTH + 6, DEPTH - 4);
            mode = $urandom_range(2);
            words.delete();
            for (int k = 0; k < size; k++) words.push_back(pick_word(mode));
            send_set(words);
            sent += size;
            if (!drained && sent >= 140) begin
                drain_results(8);
                drained = 1'b1;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        set_overflow = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_word();
        test_extremes();
        test_presorted();
        test_reversed();
        test_store_full();
        test_random_sets();

        drain_results(SETTLE);
        if (mismatch_cnt == 0 && pending_sorted_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
